[sv/lcdp_pkg.sv]
// Package with the types and constants of the display init command list player.
package lcdp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DelayW = 16;

  localparam logic [ByteW-1:0] MARK_BYTE        = 8'hFF;
  localparam logic [ByteW-1:0] DELAY_UNIT_RESET = 8'd10;

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DELAY = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

endpackage

[sv/lcd_init_command_list_player_unit.sv]
// Top level of the display init command list player: decoder and result register.
//
// The block decodes a display initialization list that arrives one byte per
// transaction on the in_ channel (valid/stall). Each entry is a command byte,
// a length byte and that many data bytes; a command of 0xFF followed by 0xFF
// marks the end of the list, and 0xFF followed by any other count is a delay
// request of count times cfg_delay_unit_ms milliseconds.
// Results leave on the out_ channel (valid/stall): a command or data byte with
// its data/command level, a delay request, or an end of list. Length bytes and
// marker bytes produce no result.
// An accepted byte's result is on the outputs in the next cycle; one byte is
// accepted in every cycle unless a stalled result is held. The phase logic and
// the 8x8 delay multiply sit between the input port and the result register.
// When the receiver stalls, the result register holds and in_stall is raised
// only while a held result is waiting; a new byte is taken in the same cycle a
// held result is taken.
// The cfg_ channel writes the delay unit and is always ready.
// Synchronous reset restores the delay unit to 10, returns the decoder to
// expecting a command byte and empties the result register.
module lcd_init_command_list_player_unit
  import lcdp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ByteW-1:0]  in_list_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [ByteW-1:0]  out_byte,
  output logic              out_is_data,
  output logic [DelayW-1:0] out_delay_ms,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ByteW-1:0]  cfg_delay_unit_ms
);

  phase_t            phase_r, phase_nxt;
  logic              marker_r, marker_nxt;
  logic [ByteW-1:0]  left_r, left_nxt;
  logic [ByteW-1:0]  unit_r;
  logic              out_valid_r, out_valid_nxt;
  kind_t             kind_r, kind_nxt;
  logic [ByteW-1:0]  byte_r, byte_nxt;
  logic              data_r, data_nxt;
  logic [DelayW-1:0] delay_r, delay_nxt;
  logic              accept;
  logic              emit;
  logic [DelayW-1:0] product;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign product   = {{(DelayW-ByteW){1'b0}}, in_list_byte}
                   * {{(DelayW-ByteW){1'b0}}, unit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CMD;
      marker_r    <= 1'b0;
      left_r      <= '0;
      unit_r      <= DELAY_UNIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      marker_r    <= marker_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unit_r <= cfg_delay_unit_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind_r  <= kind_nxt;
      byte_r  <= byte_nxt;
      data_r  <= data_nxt;
      delay_r <= delay_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    marker_nxt = marker_r;
    left_nxt   = left_r;
    emit       = 1'b0;
    kind_nxt   = KIND_BYTE;
    byte_nxt   = '0;
    data_nxt   = 1'b0;
    delay_nxt  = '0;
    case (phase_r)
      PH_LEN: begin
        phase_nxt = PH_CMD;
        if (marker_r) begin
          marker_nxt = 1'b0;
          emit       = 1'b1;
          if (in_list_byte == MARK_BYTE) begin
            kind_nxt = KIND_END;
          end else begin
            kind_nxt  = KIND_DELAY;
            delay_nxt = product;
          end
        end else begin
          left_nxt = in_list_byte;
          if (in_list_byte != '0) begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        emit     = 1'b1;
        byte_nxt = in_list_byte;
        data_nxt = 1'b1;
        left_nxt = left_r - {{(ByteW-1){1'b0}}, 1'b1};
        if (left_r == {{(ByteW-1){1'b0}}, 1'b1}) begin
          phase_nxt = PH_CMD;
        end
      end
      default: begin
        phase_nxt = PH_LEN;
        left_nxt  = '0;
        if (in_list_byte == MARK_BYTE) begin
          marker_nxt = 1'b1;
        end else begin
          marker_nxt = 1'b0;
          emit       = 1'b1;
          byte_nxt   = in_list_byte;
        end
      end
    endcase
    if (!accept) begin
      phase_nxt  = phase_r;
      marker_nxt = marker_r;
      left_nxt   = left_r;
    end
    if (accept) begin
      out_valid_nxt = emit | (out_valid_r & out_stall);
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = kind_r;
  assign out_byte     = byte_r;
  assign out_is_data  = data_r;
  assign out_delay_ms = delay_r;

`ifndef ASSERT_OFF
  a_data_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> left_r != '0)
    else $error("data phase with no bytes left");

  a_data_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_is_data |-> kind_r == KIND_BYTE)
    else $error("data flag on a result that is not a byte");

  a_cmd_emits: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_CMD && in_list_byte != MARK_BYTE |=> out_valid_r)
    else $error("command byte produced no result");

  a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_DATA && left_r == {{(ByteW-1){1'b0}}, 1'b1}
    |=> phase_r == PH_CMD)
    else $error("last data byte did not end the entry");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != KIND_DELAY |-> delay_r == '0)
    else $error("delay value on a result that is not a delay");
`endif

endmodule

[dv/lcd_init_command_list_player_unit_test.sv]
// Self-checking testbench for the display init command list player: stimulus, checker, end check.
module lcd_init_command_list_player_unit_test
  import lcdp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  class list_action_scoreboard;
    typedef struct packed {
      kind_t             kind;
      logic [ByteW-1:0]  value;
      logic              is_data;
      logic [DelayW-1:0] delay;
    } action_t;

    action_t          expected_actions[$];
    phase_t           phase;
    bit               marker_seen;
    logic [ByteW-1:0] bytes_left;
    logic [ByteW-1:0] delay_unit;
    int               errors;

    function new();
      phase       = PH_CMD;
      marker_seen = 1'b0;
      bytes_left  = '0;
      delay_unit  = DELAY_UNIT_RESET;
      errors      = 0;
    endfunction

    function void set_delay_unit(logic [ByteW-1:0] unit);
      delay_unit = unit;
    endfunction

    function int pending();
      return expected_actions.size();
    endfunction

    function void push_action(kind_t kind, logic [ByteW-1:0] value, logic is_data,
                              logic [DelayW-1:0] delay);
      action_t a;
      a.kind    = kind;
      a.value   = value;
      a.is_data = is_data;
      a.delay   = delay;
      expected_actions.push_back(a);
    endfunction

    function void note_list_byte(logic [ByteW-1:0] b);
      logic [DelayW-1:0] ms;
      case (phase)
        PH_LEN: begin
          phase = PH_CMD;
          if (marker_seen) begin
            marker_seen = 1'b0;
            if (b == MARK_BYTE) begin
              push_action(KIND_END, '0, 1'b0, '0);
            end else begin
              ms = DelayW'(b) * DelayW'(delay_unit);
              push_action(KIND_DELAY, '0, 1'b0, ms);
            end
          end else begin
            bytes_left = b;
            if (b != '0) phase = PH_DATA;
          end
        end
        PH_DATA: begin
          push_action(KIND_BYTE, b, 1'b1, '0);
          bytes_left = bytes_left - ByteW'(1);
          if (bytes_left == '0) phase = PH_CMD;
        end
        default: begin
          phase      = PH_LEN;
          bytes_left = '0;
          if (b == MARK_BYTE) begin
            marker_seen = 1'b1;
          end else begin
            marker_seen = 1'b0;
            push_action(KIND_BYTE, b, 1'b0, '0);
          end
        end
      endcase
    endfunction

    function void check_action(logic [1:0] kind, logic [ByteW-1:0] value, logic is_data,
                               logic [DelayW-1:0] delay);
      action_t a;
      if (expected_actions.size() == 0) begin
        $error("Unexpected result: kind %0d, byte %0d, is_data %0d, delay_ms %0d",
               kind, value, is_data, delay);
        errors++;
        return;
      end
      a = expected_actions.pop_front();
      if (a.kind != kind) begin
        $error("kind mismatch: expected %0d, actual %0d", a.kind, kind);
        errors++;
      end
      if (a.value != value) begin
        $error("out_byte mismatch: expected %0d, actual %0d", a.value, value);
        errors++;
      end
      if (a.is_data != is_data) begin
        $error("is_data mismatch: expected %0d, actual %0d", a.is_data, is_data);
        errors++;
      end
      if (a.delay != delay) begin
        $error("delay_ms mismatch: expected %0d, actual %0d", a.delay, delay);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ByteW-1:0]  in_list_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_kind;
  logic [ByteW-1:0]  out_byte;
  logic              out_is_data;
  logic [DelayW-1:0] out_delay_ms;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ByteW-1:0]  cfg_delay_unit_ms = '0;

  list_action_scoreboard decoder_model = new();

  bit in_no_gaps  = 1'b0;
  bit out_no_gaps = 1'b0;
  int bytes_sent  = 0;
  int stall_left  = 0;

  lcd_init_command_list_player_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_list_byte      (in_list_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_byte          (out_byte),
    .out_is_data       (out_is_data),
    .out_delay_ms      (out_delay_ms),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_delay_unit_ms (cfg_delay_unit_ms)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) decoder_model.note_list_byte(in_list_byte);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      decoder_model.check_action(out_kind, out_byte, out_is_data, out_delay_ms);
      stall_left = out_no_gaps ? 0 : $urandom_range(0, 5);
      out_stall <= (stall_left != 0);
    end else if (stall_left > 1) begin
      stall_left = stall_left - 1;
    end else begin
      stall_left = 0;
      out_stall <= 1'b0;
    end
  end

  task automatic send_list_byte(logic [ByteW-1:0] b);
    int gap;
    gap = in_no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_list_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic wait_for_actions_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoder_model.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_delay_unit(logic [ByteW-1:0] unit);
    wait_for_actions_drained();
    cfg_valid         <= 1'b1;
    cfg_delay_unit_ms <= unit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    decoder_model.set_delay_unit(unit);
  endtask

  task automatic send_random_entry();
    int pick;
    int len;
    int count;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      send_list_byte(ByteW'($urandom_range(0, 254)));
      len = ($urandom_range(0, 49) == 0) ? $urandom_range(100, 255) : $urandom_range(0, 6);
      send_list_byte(ByteW'(len));
      for (int i = 0; i < len; i++) send_list_byte(ByteW'($urandom_range(0, 255)));
    end else if (pick < 82) begin
      send_list_byte(MARK_BYTE);
      send_list_byte(ByteW'($urandom_range(0, 254)));
    end else if (pick < 88) begin
      send_list_byte(MARK_BYTE);
      send_list_byte(MARK_BYTE);
    end else begin
      count = $urandom_range(1, 4);
      for (int i = 0; i < count; i++) send_list_byte(ByteW'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [ByteW-1:0] directed_list[] = '{
      8'h00, 8'h00,
      8'h2A, 8'h03, 8'h00, 8'hFF, 8'h55,
      8'hFF, 8'h00,
      8'hFF, 8'hFE,
      8'hFE, 8'h01, 8'hAA,
      8'hFF, 8'hFF,
      8'h11, 8'h00,
      8'hFF, 8'h01
    };
    logic [ByteW-1:0] phase_units[6];
    int target;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_list[i]) send_list_byte(directed_list[i]);

    write_delay_unit(8'd255);
    send_list_byte(MARK_BYTE);
    send_list_byte(8'hFE);
    send_list_byte(MARK_BYTE);
    send_list_byte(8'h01);
    send_list_byte(MARK_BYTE);
    send_list_byte(8'h00);

    phase_units = '{8'd1, 8'd0, 8'd255, 8'd10, 8'd0, 8'd0};
    for (int i = 3; i < 6; i++) phase_units[i] = ByteW'($urandom_range(1, 255));
    target = bytes_sent;
    for (int p = 0; p < 6; p++) begin
      write_delay_unit(phase_units[p]);
      in_no_gaps  = ($urandom_range(0, 3) == 0);
      out_no_gaps = ($urandom_range(0, 3) == 0);
      target += 150;
      while (bytes_sent < target) send_random_entry();
    end

    wait_for_actions_drained();
    repeat (5) @(posedge clk);
    if (decoder_model.pending() != 0) begin
      $error("%0d expected results never arrived", decoder_model.pending());
      decoder_model.errors++;
    end
    if (decoder_model.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/lcdp_pkg.sv
sv/lcd_init_command_list_player_unit.sv
dv/lcd_init_command_list_player_unit_test.sv
